// ----- hw/rtl/tnts_pkg.sv -----
// Package for the two-node thermal step block: field widths, codes, the
// micro-program of a time step, and the controller/datapath interface types.
// No dependencies.
package tnts_pkg;

  localparam int TEMP_W    = 21;
  localparam int VALVE_W   = 17;
  localparam int PEND_W    = 40;
  localparam int HEAT_W    = 32;
  localparam int DT_W      = 24;
  localparam int SPEED_W   = 16;
  localparam int AMB_W     = 21;
  localparam int COND_W    = 25;
  localparam int INV_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int AIR_W     = 41;
  localparam int WORD_W    = 64;
  localparam int HALF_W    = 32;
  localparam int ACC_W     = 128;
  localparam int SHIFT_W   = 6;
  localparam int PHASE_W   = 4;
  localparam int CMD_W     = 2;

  // input beat layout
  localparam int HEAT_LSB  = 0;
  localparam int DT_LSB    = HEAT_LSB + HEAT_W;
  localparam int SPEED_LSB = DT_LSB + DT_W;
  localparam int S_DATA_W  = ((SPEED_LSB + SPEED_W + 7) / 8) * 8;

  // output beat layout
  localparam int TB_LSB    = 0;
  localparam int TO_LSB    = TB_LSB + TEMP_W;
  localparam int VC_LSB    = TO_LSB + TEMP_W;
  localparam int VO_LSB    = VC_LSB + VALVE_W;
  localparam int OUT_BITS  = VO_LSB + VALVE_W;
  localparam int M_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [TEMP_W-1:0]  TEMP_MAX  = '1;
  localparam logic [VALVE_W-1:0] FULL_OPEN = VALVE_W'(65536);
  localparam logic [WORD_W-1:0]  SAT_LIM   = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [AIR_W-1:0]   AIR_ONE   = AIR_W'(1) << 24;

  localparam int DEF_COOLANT_OPEN_TEMP  = 371866;
  localparam int DEF_COOLANT_FULL_TEMP  = 382106;
  localparam int DEF_OIL_OPEN_TEMP      = 392346;
  localparam int DEF_OIL_FULL_TEMP      = 402586;
  localparam int DEF_INITIAL_BLOCK_TEMP = 300186;
  localparam int DEF_INITIAL_OIL_TEMP   = 300186;

  localparam logic [PHASE_W-1:0] MUL_LAST = PHASE_W'(6);
  localparam logic [PHASE_W-1:0] DIV_LAST = PHASE_W'(2);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_BLOCK = 2'd0,
    CMD_ADD_OIL   = 2'd1,
    CMD_STEP      = 2'd2,
    CMD_RESTART   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMBIENT     = 3'd0,
    CFG_BLOCK_OIL_G = 3'd1,
    CFG_RADIATOR_G  = 3'd2,
    CFG_OIL_AMB_G   = 3'd3,
    CFG_COOLER_G    = 3'd4,
    CFG_SPEED_GAIN  = 3'd5,
    CFG_BLOCK_INV   = 3'd6,
    CFG_OIL_INV     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [AMB_W-1:0]  ambient;
    logic [COND_W-1:0] block_oil_g;
    logic [COND_W-1:0] radiator_g;
    logic [COND_W-1:0] oil_amb_g;
    logic [COND_W-1:0] cooler_g;
    logic [COND_W-1:0] speed_gain;
    logic [INV_W-1:0]  block_inv;
    logic [INV_W-1:0]  oil_inv;
  } cfg_t;

  typedef enum logic [3:0] {
    SEL_SPEED, SEL_DTBO, SEL_DTRAD, SEL_DTOA, SEL_T,
    SEL_B2O, SEL_RAD, SEL_O2A, SEL_COOL, SEL_PB, SEL_PO
  } sel_e;

  typedef enum logic [3:0] {
    OPB_GAIN, OPB_GBO, OPB_GRAD, OPB_GOA, OPB_GCOOL,
    OPB_VC, OPB_VO, OPB_AIR, OPB_DT, OPB_INVB, OPB_INVO
  } opb_e;

  typedef enum logic [2:0] {
    UOP_MUL, UOP_ADD, UOP_SUB, UOP_UPD, UOP_DIV
  } uop_kind_e;

  typedef enum logic [3:0] {
    DST_AIR, DST_B2O, DST_RAD, DST_O2A, DST_COOL, DST_T, DST_VC, DST_VO, DST_TEMPS
  } dst_e;

  typedef struct packed {
    uop_kind_e           kind;
    sel_e                a;
    sel_e                c;
    opb_e                b;
    logic [SHIFT_W-1:0]  shift;
    dst_e                dst;
  } uop_t;

  localparam int PROG_LEN = 21;
  localparam int PC_W     = $clog2(PROG_LEN);

  localparam uop_t PROG [PROG_LEN] = '{
    '{UOP_MUL, SEL_SPEED, SEL_SPEED, OPB_GAIN,  6'd0,  DST_AIR},
    '{UOP_MUL, SEL_DTBO,  SEL_DTBO,  OPB_GBO,   6'd0,  DST_B2O},
    '{UOP_MUL, SEL_DTRAD, SEL_DTRAD, OPB_GRAD,  6'd0,  DST_T},
    '{UOP_MUL, SEL_T,     SEL_T,     OPB_VC,    6'd16, DST_T},
    '{UOP_MUL, SEL_T,     SEL_T,     OPB_AIR,   6'd24, DST_RAD},
    '{UOP_MUL, SEL_DTOA,  SEL_DTOA,  OPB_GOA,   6'd0,  DST_O2A},
    '{UOP_MUL, SEL_DTOA,  SEL_DTOA,  OPB_GCOOL, 6'd0,  DST_T},
    '{UOP_MUL, SEL_T,     SEL_T,     OPB_VO,    6'd16, DST_T},
    '{UOP_MUL, SEL_T,     SEL_T,     OPB_AIR,   6'd24, DST_COOL},
    '{UOP_ADD, SEL_B2O,   SEL_RAD,   OPB_GAIN,  6'd0,  DST_RAD},
    '{UOP_ADD, SEL_O2A,   SEL_COOL,  OPB_GAIN,  6'd0,  DST_COOL},
    '{UOP_SUB, SEL_COOL,  SEL_B2O,   OPB_GAIN,  6'd0,  DST_COOL},
    '{UOP_MUL, SEL_RAD,   SEL_RAD,   OPB_DT,    6'd34, DST_RAD},
    '{UOP_MUL, SEL_COOL,  SEL_COOL,  OPB_DT,    6'd34, DST_COOL},
    '{UOP_SUB, SEL_PB,    SEL_RAD,   OPB_GAIN,  6'd0,  DST_RAD},
    '{UOP_SUB, SEL_PO,    SEL_COOL,  OPB_GAIN,  6'd0,  DST_COOL},
    '{UOP_MUL, SEL_RAD,   SEL_RAD,   OPB_INVB,  6'd30, DST_RAD},
    '{UOP_MUL, SEL_COOL,  SEL_COOL,  OPB_INVO,  6'd30, DST_COOL},
    '{UOP_UPD, SEL_RAD,   SEL_COOL,  OPB_GAIN,  6'd0,  DST_TEMPS},
    '{UOP_DIV, SEL_T,     SEL_T,     OPB_GAIN,  6'd0,  DST_VC},
    '{UOP_DIV, SEL_T,     SEL_T,     OPB_GAIN,  6'd0,  DST_VO}
  };

  typedef enum logic [2:0] {
    DP_NOP, DP_CAPTURE, DP_HEAT_B, DP_HEAT_O, DP_RESTART, DP_UOP, DP_OUT_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    uop_t                uop;
    logic [PHASE_W-1:0]  phase;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic dt_zero;
  } dp_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_DECODE, ST_RUN, ST_FINISH
  } ctrl_state_e;

endpackage

// ----- hw/rtl/tnts_cfg.sv -----
// Configuration register bank of the thermal step block.
// Depends on tnts_pkg.
module tnts_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [tnts_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [tnts_pkg::CFG_W-1:0]      data_i,
  output tnts_pkg::cfg_t                  cfg_o
);
  import tnts_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ambient     <= AMB_W'(300186);
      cfg_q.block_oil_g <= COND_W'(25600);
      cfg_q.radiator_g  <= COND_W'(256000);
      cfg_q.oil_amb_g   <= COND_W'(2560);
      cfg_q.cooler_g    <= COND_W'(12800);
      cfg_q.speed_gain  <= COND_W'(3277);
      cfg_q.block_inv   <= INV_W'(214748);
      cfg_q.oil_inv     <= INV_W'(858993);
    end else if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_AMBIENT:     cfg_q.ambient     <= data_i[AMB_W-1:0];
        CFG_BLOCK_OIL_G: cfg_q.block_oil_g <= data_i[COND_W-1:0];
        CFG_RADIATOR_G:  cfg_q.radiator_g  <= data_i[COND_W-1:0];
        CFG_OIL_AMB_G:   cfg_q.oil_amb_g   <= data_i[COND_W-1:0];
        CFG_COOLER_G:    cfg_q.cooler_g    <= data_i[COND_W-1:0];
        CFG_SPEED_GAIN:  cfg_q.speed_gain  <= data_i[COND_W-1:0];
        CFG_BLOCK_INV:   cfg_q.block_inv   <= data_i[INV_W-1:0];
        CFG_OIL_INV:     cfg_q.oil_inv     <= data_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/tnts_dp.sv -----
// Datapath of the thermal step block: node state, shared 32x32 multiplier
// with wide accumulator, saturating adder and reciprocal valve scaler.
// Depends on tnts_pkg; driven by tnts_ctrl.
module tnts_dp #(
  parameter int COOLANT_OPEN_TEMP  = tnts_pkg::DEF_COOLANT_OPEN_TEMP,
  parameter int COOLANT_FULL_TEMP  = tnts_pkg::DEF_COOLANT_FULL_TEMP,
  parameter int OIL_OPEN_TEMP      = tnts_pkg::DEF_OIL_OPEN_TEMP,
  parameter int OIL_FULL_TEMP      = tnts_pkg::DEF_OIL_FULL_TEMP,
  parameter int INITIAL_BLOCK_TEMP = tnts_pkg::DEF_INITIAL_BLOCK_TEMP,
  parameter int INITIAL_OIL_TEMP   = tnts_pkg::DEF_INITIAL_OIL_TEMP
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tnts_pkg::cfg_t                 cfg_i,
  input  tnts_pkg::dp_cmd_t              cmd_i,
  output tnts_pkg::dp_stat_t             stat_o,
  input  logic [tnts_pkg::CMD_W-1:0]     in_cmd_i,
  input  logic [tnts_pkg::S_DATA_W-1:0]  in_data_i,
  output logic [tnts_pkg::M_DATA_W-1:0]  out_data_o
);
  import tnts_pkg::*;

  localparam logic [TEMP_W-1:0] C_OPEN = TEMP_W'(COOLANT_OPEN_TEMP);
  localparam logic [TEMP_W-1:0] C_FULL = TEMP_W'(COOLANT_FULL_TEMP);
  localparam bit                C_STEP = (COOLANT_FULL_TEMP <= COOLANT_OPEN_TEMP);
  localparam logic [TEMP_W-1:0] O_OPEN = TEMP_W'(OIL_OPEN_TEMP);
  localparam logic [TEMP_W-1:0] O_FULL = TEMP_W'(OIL_FULL_TEMP);
  localparam bit                O_STEP = (OIL_FULL_TEMP <= OIL_OPEN_TEMP);

  // floor(x * 65536 / span) = (x * rcp) >> (2 * l) for x < span <= 2^l
  localparam int RCP_W = 40;
  localparam int C_D   = C_STEP ? 1 : (COOLANT_FULL_TEMP - COOLANT_OPEN_TEMP);
  localparam int C_L   = $clog2(C_D);
  localparam int O_D   = O_STEP ? 1 : (OIL_FULL_TEMP - OIL_OPEN_TEMP);
  localparam int O_L   = $clog2(O_D);
  localparam logic [RCP_W-1:0] C_RCP =
      RCP_W'(((longint'(1) << (16 + 2 * C_L)) + longint'(C_D) - 1) / longint'(C_D));
  localparam logic [RCP_W-1:0] O_RCP =
      RCP_W'(((longint'(1) << (16 + 2 * O_L)) + longint'(O_D) - 1) / longint'(O_D));
  localparam logic [SHIFT_W-1:0] C_SH = SHIFT_W'(2 * C_L);
  localparam logic [SHIFT_W-1:0] O_SH = SHIFT_W'(2 * O_L);

  localparam longint C_INIT = C_STEP ?
      ((INITIAL_BLOCK_TEMP >= COOLANT_OPEN_TEMP) ? 65536 : 0) :
      ((INITIAL_BLOCK_TEMP <= COOLANT_OPEN_TEMP) ? 0 :
       (INITIAL_BLOCK_TEMP >= COOLANT_FULL_TEMP) ? 65536 :
       ((longint'(INITIAL_BLOCK_TEMP) - longint'(COOLANT_OPEN_TEMP)) * 65536) /
       (longint'(COOLANT_FULL_TEMP) - longint'(COOLANT_OPEN_TEMP)));
  localparam longint O_INIT = O_STEP ?
      ((INITIAL_OIL_TEMP >= OIL_OPEN_TEMP) ? 65536 : 0) :
      ((INITIAL_OIL_TEMP <= OIL_OPEN_TEMP) ? 0 :
       (INITIAL_OIL_TEMP >= OIL_FULL_TEMP) ? 65536 :
       ((longint'(INITIAL_OIL_TEMP) - longint'(OIL_OPEN_TEMP)) * 65536) /
       (longint'(OIL_FULL_TEMP) - longint'(OIL_OPEN_TEMP)));
  localparam logic [VALVE_W-1:0] VC_INIT = VALVE_W'(C_INIT);
  localparam logic [VALVE_W-1:0] VO_INIT = VALVE_W'(O_INIT);

  localparam logic signed [WORD_W:0] SAT_POS = (WORD_W+1)'(SAT_LIM);
  localparam logic signed [WORD_W:0] SAT_NEG = -SAT_POS;
  localparam logic signed [PEND_W:0] PEND_POS = (PEND_W+1)'({1'b0, {(PEND_W-1){1'b1}}});
  localparam logic signed [PEND_W:0] PEND_NEG = -PEND_POS - (PEND_W+1)'(1);

  // node state
  logic [TEMP_W-1:0]        tb_q, to_q;
  logic [VALVE_W-1:0]       vc_q, vo_q;
  logic signed [PEND_W-1:0] pb_q, po_q;

  // captured beat
  cmd_e                      cmd_q;
  logic signed [HEAT_W-1:0]  heat_q;
  logic [DT_W-1:0]           dt_q;
  logic signed [SPEED_W-1:0] speed_q;

  // work registers
  logic [AIR_W-1:0]         air_q;
  logic signed [WORD_W-1:0] b2o_q, rad_q, o2a_q, cool_q, t_q;

  // multiplier
  logic [WORD_W-1:0] ma_q, mb_q, pp_q;
  logic              neg_q;
  logic [1:0]        pp_sh_q;
  logic [ACC_W-1:0]  acc_q;

  // valve scaler
  logic [TEMP_W-1:0]  dr_q;
  logic [VALVE_W-1:0] dq_q, dres_q;
  logic               dspec_q;

  logic [M_DATA_W-1:0] out_q;

  uop_t               uop;
  logic [PHASE_W-1:0] phase;
  logic               run;
  assign uop   = cmd_i.uop;
  assign phase = cmd_i.phase;
  assign run   = (cmd_i.op == DP_UOP);

  logic signed [WORD_W-1:0] tb_w, to_w, amb_w;
  assign tb_w  = WORD_W'(tb_q);
  assign to_w  = WORD_W'(to_q);
  assign amb_w = WORD_W'(cfg_i.ambient);

  function automatic logic signed [WORD_W-1:0] sel_word(sel_e s);
    logic signed [WORD_W-1:0] v;
    case (s)
      SEL_SPEED: v = WORD_W'(speed_q);
      SEL_DTBO:  v = tb_w - to_w;
      SEL_DTRAD: v = tb_w - amb_w;
      SEL_DTOA:  v = to_w - amb_w;
      SEL_T:     v = t_q;
      SEL_B2O:   v = b2o_q;
      SEL_RAD:   v = rad_q;
      SEL_O2A:   v = o2a_q;
      SEL_COOL:  v = cool_q;
      SEL_PB:    v = WORD_W'(pb_q);
      SEL_PO:    v = WORD_W'(po_q);
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [TEMP_W-1:0] clamp_temp(logic signed [WORD_W-1:0] v);
    logic [TEMP_W-1:0] r;
    if (v < 0) r = '0;
    else if (v > WORD_W'(TEMP_MAX)) r = TEMP_MAX;
    else r = v[TEMP_W-1:0];
    return r;
  endfunction

  function automatic logic signed [PEND_W-1:0] sat_pend(logic signed [PEND_W:0] v);
    logic signed [PEND_W-1:0] r;
    if (v > PEND_POS) r = PEND_POS[PEND_W-1:0];
    else if (v < PEND_NEG) r = PEND_NEG[PEND_W-1:0];
    else r = v[PEND_W-1:0];
    return r;
  endfunction

  logic signed [WORD_W-1:0] a_val, c_val, c_eff;
  logic [WORD_W-1:0]        a_mag, b_val;
  assign a_val = sel_word(uop.a);
  assign c_val = sel_word(uop.c);
  assign a_mag = a_val[WORD_W-1] ? WORD_W'(-a_val) : WORD_W'(a_val);
  assign c_eff = (uop.kind == UOP_SUB) ? -c_val : c_val;

  always_comb begin
    case (uop.b)
      OPB_GAIN:  b_val = WORD_W'(cfg_i.speed_gain);
      OPB_GBO:   b_val = WORD_W'(cfg_i.block_oil_g);
      OPB_GRAD:  b_val = WORD_W'(cfg_i.radiator_g);
      OPB_GOA:   b_val = WORD_W'(cfg_i.oil_amb_g);
      OPB_GCOOL: b_val = WORD_W'(cfg_i.cooler_g);
      OPB_VC:    b_val = WORD_W'(vc_q);
      OPB_VO:    b_val = WORD_W'(vo_q);
      OPB_AIR:   b_val = WORD_W'(air_q);
      OPB_DT:    b_val = WORD_W'(dt_q);
      OPB_INVB:  b_val = WORD_W'(cfg_i.block_inv);
      OPB_INVO:  b_val = WORD_W'(cfg_i.oil_inv);
      default:   b_val = '0;
    endcase
  end

  // partial products: k = phase - 1, a half = k[0], b half = k[1]
  logic [1:0]        pp_k;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [WORD_W-1:0] mul_p;
  logic [ACC_W-1:0]  pp_wide;
  assign pp_k  = 2'(phase - PHASE_W'(1));
  assign mul_a = pp_k[0] ? ma_q[WORD_W-1:HALF_W] : ma_q[HALF_W-1:0];
  assign mul_b = pp_k[1] ? mb_q[WORD_W-1:HALF_W] : mb_q[HALF_W-1:0];
  assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

  always_comb begin
    case (pp_sh_q)
      2'd0:    pp_wide = ACC_W'(pp_q);
      2'd1:    pp_wide = ACC_W'(pp_q) << HALF_W;
      2'd2:    pp_wide = ACC_W'(pp_q) << WORD_W;
      default: pp_wide = '0;
    endcase
  end

  logic [ACC_W-1:0]         acc_sh;
  logic [WORD_W-1:0]        mul_mag;
  logic signed [WORD_W-1:0] mul_res;
  assign acc_sh  = acc_q >> uop.shift;
  assign mul_mag = (|acc_sh[ACC_W-1:WORD_W-2]) ? SAT_LIM : acc_sh[WORD_W-1:0];
  assign mul_res = neg_q ? -$signed(mul_mag) : $signed(mul_mag);

  logic signed [WORD_W:0]   sum_w;
  logic signed [WORD_W-1:0] add_res;
  assign sum_w = (WORD_W+1)'(a_val) + (WORD_W+1)'(c_eff);
  always_comb begin
    if (sum_w > SAT_POS) add_res = SAT_POS[WORD_W-1:0];
    else if (sum_w < SAT_NEG) add_res = SAT_NEG[WORD_W-1:0];
    else add_res = sum_w[WORD_W-1:0];
  end

  logic signed [WORD_W-1:0] res_val;
  logic                     res_we;
  always_comb begin
    res_val = add_res;
    res_we  = 1'b0;
    if (run) begin
      case (uop.kind)
        UOP_MUL: begin
          res_val = mul_res;
          res_we  = (phase == MUL_LAST);
        end
        UOP_ADD, UOP_SUB: res_we = 1'b1;
        default: ;
      endcase
    end
  end

  // valve scaler
  logic [TEMP_W-1:0]  dv_t, dv_open, dv_full;
  logic [RCP_W-1:0]   dv_rcp;
  logic [SHIFT_W-1:0] dv_sh;
  logic               dv_step;
  always_comb begin
    if (uop.dst == DST_VO) begin
      dv_t = to_q; dv_open = O_OPEN; dv_full = O_FULL; dv_step = O_STEP;
      dv_rcp = O_RCP; dv_sh = O_SH;
    end else begin
      dv_t = tb_q; dv_open = C_OPEN; dv_full = C_FULL; dv_step = C_STEP;
      dv_rcp = C_RCP; dv_sh = C_SH;
    end
  end

  logic [TEMP_W+RCP_W-1:0] dv_prod;
  assign dv_prod = (TEMP_W+RCP_W)'(dr_q) * (TEMP_W+RCP_W)'(dv_rcp);

  logic [VALVE_W-1:0] valve_res;
  assign valve_res = dspec_q ? dres_q : dq_q;

  logic signed [PEND_W:0] hsum_b, hsum_o;
  assign hsum_b = (PEND_W+1)'(pb_q) + (PEND_W+1)'(heat_q);
  assign hsum_o = (PEND_W+1)'(po_q) + (PEND_W+1)'(heat_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tb_q  <= TEMP_W'(INITIAL_BLOCK_TEMP);
      to_q  <= TEMP_W'(INITIAL_OIL_TEMP);
      vc_q  <= VC_INIT;
      vo_q  <= VO_INIT;
      pb_q  <= '0;
      po_q  <= '0;
      cmd_q <= CMD_ADD_BLOCK;
    end else begin
      case (cmd_i.op)
        DP_CAPTURE: cmd_q <= cmd_e'(in_cmd_i);
        DP_HEAT_B:  pb_q <= sat_pend(hsum_b);
        DP_HEAT_O:  po_q <= sat_pend(hsum_o);
        DP_RESTART: begin
          tb_q <= TEMP_W'(INITIAL_BLOCK_TEMP);
          to_q <= TEMP_W'(INITIAL_OIL_TEMP);
          vc_q <= VC_INIT;
          vo_q <= VO_INIT;
          pb_q <= '0;
          po_q <= '0;
        end
        DP_UOP: begin
          if (uop.kind == UOP_UPD) begin
            tb_q <= clamp_temp(tb_w + rad_q);
            to_q <= clamp_temp(to_w + cool_q);
            pb_q <= '0;
            po_q <= '0;
          end else if (uop.kind == UOP_DIV && phase == DIV_LAST) begin
            if (uop.dst == DST_VO) vo_q <= valve_res;
            else vc_q <= valve_res;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_CAPTURE) begin
      heat_q  <= in_data_i[HEAT_LSB +: HEAT_W];
      dt_q    <= in_data_i[DT_LSB +: DT_W];
      speed_q <= in_data_i[SPEED_LSB +: SPEED_W];
    end
    if (cmd_i.op == DP_OUT_LOAD) begin
      out_q <= M_DATA_W'({vo_q, vc_q, to_q, tb_q});
    end
    if (res_we) begin
      case (uop.dst)
        DST_AIR:  air_q  <= AIR_W'(mul_mag) + AIR_ONE;
        DST_B2O:  b2o_q  <= res_val;
        DST_RAD:  rad_q  <= res_val;
        DST_O2A:  o2a_q  <= res_val;
        DST_COOL: cool_q <= res_val;
        DST_T:    t_q    <= res_val;
        default: ;
      endcase
    end
    if (run && uop.kind == UOP_MUL) begin
      if (phase == '0) begin
        ma_q  <= a_mag;
        neg_q <= a_val[WORD_W-1];
        mb_q  <= b_val;
        acc_q <= '0;
      end else begin
        if (phase <= PHASE_W'(4)) begin
          pp_q    <= mul_p;
          pp_sh_q <= 2'(pp_k[0]) + 2'(pp_k[1]);
        end
        if (phase >= PHASE_W'(2) && phase <= PHASE_W'(5)) acc_q <= acc_q + pp_wide;
      end
    end
    if (run && uop.kind == UOP_DIV) begin
      if (phase == '0) begin
        dq_q <= '0;
        dr_q <= dv_t - dv_open;
        if (dv_step) begin
          dspec_q <= 1'b1;
          dres_q  <= (dv_t >= dv_open) ? FULL_OPEN : '0;
        end else if (dv_t <= dv_open) begin
          dspec_q <= 1'b1;
          dres_q  <= '0;
        end else if (dv_t >= dv_full) begin
          dspec_q <= 1'b1;
          dres_q  <= FULL_OPEN;
        end else begin
          dspec_q <= 1'b0;
        end
      end else if (phase == PHASE_W'(1)) begin
        dq_q <= VALVE_W'(dv_prod >> dv_sh);
      end
    end
  end

  assign stat_o.cmd     = cmd_q;
  assign stat_o.dt_zero = (dt_q == '0);
  assign out_data_o     = out_q;

endmodule

// ----- hw/rtl/tnts_ctrl.sv -----
// Controller of the thermal step block: beat handshakes, command decode and
// the micro-program sequencer of a time step.
// Depends on tnts_pkg; drives tnts_dp.
module tnts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  input  tnts_pkg::dp_stat_t  stat_i,
  output tnts_pkg::dp_cmd_t   cmd_o
);
  import tnts_pkg::*;

  ctrl_state_e        state_q, state_d;
  logic [PC_W-1:0]    pc_q, pc_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               m_valid_q, m_valid_d;
  logic [PHASE_W-1:0] last_phase;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pc_q      <= '0;
      phase_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      phase_q   <= phase_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    case (PROG[pc_q].kind)
      UOP_MUL: last_phase = MUL_LAST;
      UOP_DIV: last_phase = DIV_LAST;
      default: last_phase = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    phase_d     = phase_q;
    m_valid_d   = m_valid_q && !m_ready_i;
    s_ready_o   = (state_q == ST_IDLE);
    cmd_o.op    = DP_NOP;
    cmd_o.uop   = PROG[pc_q];
    cmd_o.phase = phase_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.op = DP_CAPTURE;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        pc_d    = '0;
        phase_d = '0;
        state_d = ST_FINISH;
        case (stat_i.cmd)
          CMD_ADD_BLOCK: cmd_o.op = DP_HEAT_B;
          CMD_ADD_OIL:   cmd_o.op = DP_HEAT_O;
          CMD_RESTART:   cmd_o.op = DP_RESTART;
          CMD_STEP:      if (!stat_i.dt_zero) state_d = ST_RUN;
          default: ;
        endcase
      end
      ST_RUN: begin
        cmd_o.op = DP_UOP;
        if (phase_q == last_phase) begin
          phase_d = '0;
          if (pc_q == PC_W'(PROG_LEN - 1)) begin
            state_d = ST_FINISH;
          end else begin
            pc_d = pc_q + PC_W'(1);
          end
        end else begin
          phase_d = phase_q + PHASE_W'(1);
        end
      end
      ST_FINISH: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.op  = DP_OUT_LOAD;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_valid_o = m_valid_q;

endmodule

// ----- hw/rtl/two_node_thermal_step.sv -----
// Two-node (block/oil) engine thermal step, top level.
// Heat-add, restart, zero-duration beats: result registered once the output is free.
// Time step beats: run the micro-program on the shared 32x32 multiplier
// (13 wide products) and two reciprocal valve scalings, then register the result.
// One beat in flight; the next beat is taken once its result is registered.
// Reset (async, active low) restores initial temperatures and register values.
module two_node_thermal_step #(
  parameter int COOLANT_OPEN_TEMP  = tnts_pkg::DEF_COOLANT_OPEN_TEMP,
  parameter int COOLANT_FULL_TEMP  = tnts_pkg::DEF_COOLANT_FULL_TEMP,
  parameter int OIL_OPEN_TEMP      = tnts_pkg::DEF_OIL_OPEN_TEMP,
  parameter int OIL_FULL_TEMP      = tnts_pkg::DEF_OIL_FULL_TEMP,
  parameter int INITIAL_BLOCK_TEMP = tnts_pkg::DEF_INITIAL_BLOCK_TEMP,
  parameter int INITIAL_OIL_TEMP   = tnts_pkg::DEF_INITIAL_OIL_TEMP
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // heat_energy[31:0], step_duration[55:32], vehicle_speed[71:56]
  input  logic [tnts_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // command[1:0]
  input  logic [tnts_pkg::CMD_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // block_temperature[20:0], oil_temperature[41:21],
  // coolant_valve_opening[58:42], oil_valve_opening[75:59], zero[79:76]
  output logic [tnts_pkg::M_DATA_W-1:0]   m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [tnts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tnts_pkg::CFG_W-1:0]      cfg_data_i
);
  import tnts_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  tnts_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  tnts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd)
  );

  tnts_dp #(
    .COOLANT_OPEN_TEMP  (COOLANT_OPEN_TEMP),
    .COOLANT_FULL_TEMP  (COOLANT_FULL_TEMP),
    .OIL_OPEN_TEMP      (OIL_OPEN_TEMP),
    .OIL_FULL_TEMP      (OIL_FULL_TEMP),
    .INITIAL_BLOCK_TEMP (INITIAL_BLOCK_TEMP),
    .INITIAL_OIL_TEMP   (INITIAL_OIL_TEMP)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .in_cmd_i   (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("beat accepted while another is in flight");

  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result registered without returning to idle");

  a_coolant_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[VC_LSB +: VALVE_W] == FULL_OPEN) |->
    (m_axis_tdata[TB_LSB +: TEMP_W] >= TEMP_W'(COOLANT_OPEN_TEMP)))
    else $error("coolant valve full below its open temperature");

  a_oil_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[VO_LSB +: VALVE_W] == FULL_OPEN) |->
    (m_axis_tdata[TO_LSB +: TEMP_W] >= TEMP_W'(OIL_OPEN_TEMP)))
    else $error("oil valve full below its open temperature");

endmodule

// ----- sim/two_node_thermal_step_tb.sv -----
// Testbench for two_node_thermal_step: a stimulus table, then random beats under
// several register settings. Results are checked against an in-bench thermal predictor.
// Depends on tnts_pkg and the two_node_thermal_step RTL.
module two_node_thermal_step_tb;
  import tnts_pkg::*;

  localparam longint SAT        = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint PEND_HI    = 64'sd549755813887;
  localparam longint PEND_LO    = -64'sd549755813888;
  localparam int     CYCLE_CAP  = 2000000;
  localparam int     RAND_BEATS = 90;

  typedef struct packed {
    logic [TEMP_W-1:0]  tb;
    logic [TEMP_W-1:0]  to;
    logic [VALVE_W-1:0] vc;
    logic [VALVE_W-1:0] vo;
  } temps_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [HEAT_W-1:0] heat;
    logic [DT_W-1:0]   dt;
    logic [SPEED_W-1:0] speed;
    logic              typed;
    temps_t            want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  two_node_thermal_step dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // model state
  longint amb_t, g_bo, g_rad, g_oa, g_cool, air_gain, inv_b, inv_o;
  longint temp_b, temp_o, heat_b, heat_o;
  temps_t temps_due[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  function automatic longint mul_shift(longint unsigned a, longint unsigned b, int s);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> s;
    if (p > 128'(SAT)) return SAT;
    return longint'(p[63:0]);
  endfunction

  function automatic longint smul(longint a, longint unsigned b, int s);
    longint r;
    r = mul_shift(a < 0 ? -a : a, b, s);
    return a < 0 ? -r : r;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint r;
    r = a + b;
    if (r > SAT) return SAT;
    if (r < -SAT) return -SAT;
    return r;
  endfunction

  function automatic longint opening(longint t, longint op, longint full);
    if (full - op <= 0) return t >= op ? 65536 : 0;
    if (t <= op) return 0;
    if (t >= full) return 65536;
    return ((t - op) * 65536) / (full - op);
  endfunction

  function automatic longint clamp_t(longint t);
    if (t < 0) return 0;
    if (t > 2097151) return 2097151;
    return t;
  endfunction

  function automatic longint clamp_p(longint v);
    if (v > PEND_HI) return PEND_HI;
    if (v < PEND_LO) return PEND_LO;
    return v;
  endfunction

  task automatic restore_defaults();
    amb_t = 300186; g_bo = 25600; g_rad = 256000; g_oa = 2560; g_cool = 12800;
    air_gain = 3277; inv_b = 214748; inv_o = 858993;
    temp_b = DEF_INITIAL_BLOCK_TEMP; temp_o = DEF_INITIAL_OIL_TEMP;
    heat_b = 0; heat_o = 0;
  endtask

  function automatic temps_t advance_thermal(cmd_e cmd, logic [HEAT_W-1:0] heat,
                                             logic [DT_W-1:0] dt, logic [SPEED_W-1:0] spd);
    longint h, mag, air, oc, oo, b2o, rad, o2a, cool, out_b, out_o, eb, eo;
    temps_t r;
    h = longint'(signed'(heat));
    mag = longint'(signed'(spd));
    if (mag < 0) mag = -mag;
    case (cmd)
      CMD_ADD_BLOCK: heat_b = clamp_p(heat_b + h);
      CMD_ADD_OIL:   heat_o = clamp_p(heat_o + h);
      CMD_STEP: begin
        if (dt != 0) begin
          air = (64'sd1 << 24) + air_gain * mag;
          oc = opening(temp_b, DEF_COOLANT_OPEN_TEMP, DEF_COOLANT_FULL_TEMP);
          oo = opening(temp_o, DEF_OIL_OPEN_TEMP, DEF_OIL_FULL_TEMP);
          b2o = g_bo * (temp_b - temp_o);
          rad = smul(smul(g_rad * (temp_b - amb_t), oc, 16), air, 24);
          o2a = g_oa * (temp_o - amb_t);
          cool = smul(smul(g_cool * (temp_o - amb_t), oo, 16), air, 24);
          out_b = sat_sum(b2o, rad);
          out_o = sat_sum(sat_sum(o2a, cool), -b2o);
          eb = heat_b - smul(out_b, longint'(dt), 34);
          eo = heat_o - smul(out_o, longint'(dt), 34);
          heat_b = 0;
          heat_o = 0;
          temp_b = clamp_t(sat_sum(temp_b, smul(eb, inv_b, 30)));
          temp_o = clamp_t(sat_sum(temp_o, smul(eo, inv_o, 30)));
        end
      end
      default: begin
        temp_b = DEF_INITIAL_BLOCK_TEMP;
        temp_o = DEF_INITIAL_OIL_TEMP;
        heat_b = 0;
        heat_o = 0;
      end
    endcase
    r.tb = TEMP_W'(temp_b);
    r.to = TEMP_W'(temp_o);
    r.vc = VALVE_W'(opening(temp_b, DEF_COOLANT_OPEN_TEMP, DEF_COOLANT_FULL_TEMP));
    r.vo = VALVE_W'(opening(temp_o, DEF_OIL_OPEN_TEMP, DEF_OIL_FULL_TEMP));
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    temps_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.tb = m_axis_tdata[TB_LSB +: TEMP_W];
      got.to = m_axis_tdata[TO_LSB +: TEMP_W];
      got.vc = m_axis_tdata[VC_LSB +: VALVE_W];
      got.vo = m_axis_tdata[VO_LSB +: VALVE_W];
      if (temps_due.size() == 0) begin
        flag_mismatch("unexpected beat", 0, 0);
      end else begin
        want = temps_due.pop_front();
        if (got.tb != want.tb) flag_mismatch("block_temperature", got.tb, want.tb);
        if (got.to != want.to) flag_mismatch("oil_temperature", got.to, want.to);
        if (got.vc != want.vc) flag_mismatch("coolant_valve_opening", got.vc, want.vc);
        if (got.vo != want.vo) flag_mismatch("oil_valve_opening", got.vo, want.vo);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_beat(cmd_e cmd, logic [HEAT_W-1:0] heat, logic [DT_W-1:0] dt,
                           logic [SPEED_W-1:0] spd, bit typed, temps_t want);
    temps_t pred;
    if (!calm && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {spd, dt, heat};
    pred = advance_thermal(cmd, heat, dt, spd);
    temps_due.push_back(typed ? want : pred);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_regs(logic [CFG_W-1:0] v[8]);
    s_axis_tvalid <= 1'b0;
    wait (temps_due.size() == 0);
    repeat (150) @(posedge clk_i);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_idx_e'(i);
      cfg_data_i <= v[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    amb_t = v[CFG_AMBIENT] & 32'h1F_FFFF;
    g_bo = v[CFG_BLOCK_OIL_G] & 32'h1FF_FFFF;
    g_rad = v[CFG_RADIATOR_G] & 32'h1FF_FFFF;
    g_oa = v[CFG_OIL_AMB_G] & 32'h1FF_FFFF;
    g_cool = v[CFG_COOLER_G] & 32'h1FF_FFFF;
    air_gain = v[CFG_SPEED_GAIN] & 32'h1FF_FFFF;
    inv_b = longint'(v[CFG_BLOCK_INV]);
    inv_o = longint'(v[CFG_OIL_INV]);
  endtask

  function automatic logic [HEAT_W-1:0] rand_heat();
    int h;
    h = $urandom;
    return HEAT_W'(h >>> $urandom_range(0, 12));
  endfunction

  task automatic random_beats(int n);
    int k;
    cmd_e c;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      c = k < 35 ? CMD_ADD_BLOCK : k < 60 ? CMD_ADD_OIL : k < 95 ? CMD_STEP : CMD_RESTART;
      send_beat(c, $urandom_range(0, 9) == 0 ? HEAT_W'($urandom) : rand_heat(),
                $urandom_range(0, 19) == 0 ? DT_W'(0) : DT_W'($urandom >> $urandom_range(0, 20)),
                SPEED_W'($urandom), 1'b0, '0);
    end
  endtask

  localparam temps_t AT_START = '{300186, 300186, 0, 0};

  row_t steer [16] = '{
    '{CMD_RESTART,   32'h0000_0000, 24'h00_0000, 16'h0000, 1'b1, AT_START},
    '{CMD_ADD_BLOCK, 32'h7FFF_FFFF, 24'h00_0000, 16'h0000, 1'b1, AT_START},
    '{CMD_ADD_OIL,   32'h8000_0000, 24'hFF_FFFF, 16'hFFFF, 1'b1, AT_START},
    '{CMD_STEP,      32'hFFFF_FFFF, 24'h00_0000, 16'h7FFF, 1'b1, AT_START},
    '{CMD_STEP,      32'h0000_0000, 24'hFF_FFFF, 16'h8000, 1'b0, '0},
    '{CMD_ADD_BLOCK, 32'h8000_0000, 24'h00_0000, 16'h0000, 1'b0, '0},
    '{CMD_STEP,      32'h0000_0000, 24'h00_0001, 16'h7FFF, 1'b0, '0},
    '{CMD_ADD_OIL,   32'h7FFF_FFFF, 24'h00_0000, 16'h0000, 1'b0, '0},
    '{CMD_STEP,      32'h0000_0000, 24'h80_0000, 16'hFFFF, 1'b0, '0},
    '{CMD_RESTART,   32'h1234_5678, 24'hFF_FFFF, 16'h8000, 1'b1, AT_START},
    '{CMD_ADD_BLOCK, 32'h15F0_0000, 24'h00_0000, 16'h0000, 1'b0, '0},
    '{CMD_ADD_OIL,   32'h0739_0000, 24'h00_0000, 16'h0000, 1'b0, '0},
    '{CMD_STEP,      32'h0000_0000, 24'h00_0000, 16'h0100, 1'b0, '0},
    '{CMD_STEP,      32'h0000_0000, 24'h10_0000, 16'h0100, 1'b0, '0},
    '{CMD_STEP,      32'h0000_0000, 24'h10_0000, 16'hFF00, 1'b0, '0},
    '{CMD_RESTART,   32'h0000_0000, 24'h00_0000, 16'h0000, 1'b1, AT_START}
  };

  initial begin
    logic [CFG_W-1:0] v[8];
    restore_defaults();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steer[i])
      send_beat(steer[i].cmd, steer[i].heat, steer[i].dt, steer[i].speed,
                steer[i].typed, steer[i].want);

    // pending saturation and temperature limits
    for (int i = 0; i < 300; i++)
      send_beat(CMD_ADD_BLOCK, 32'h7FFF_FFFF, 24'h00_0000, 16'h0000, 1'b0, '0);
    for (int i = 0; i < 300; i++)
      send_beat(CMD_ADD_OIL, 32'h8000_0000, 24'h00_0000, 16'h0000, 1'b0, '0);
    send_beat(CMD_STEP, 32'h0000_0000, 24'h00_0010, 16'h0000, 1'b0, '0);
    random_beats(RAND_BEATS);

    // extremes, no idling
    calm = 1'b1;
    v = '{32'h1F_FFFF, 32'h1FF_FFFF, 32'h1FF_FFFF, 32'h1FF_FFFF, 32'h1FF_FFFF,
          32'h1FF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    write_regs(v);
    random_beats(RAND_BEATS);
    calm = 1'b0;

    // zero inverse masses freeze both nodes
    v = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    write_regs(v);
    random_beats(RAND_BEATS / 2);

    // long receiver hold-off
    foreach (v[i]) v[i] = $urandom;
    write_regs(v);
    hold_req = 1'b1;
    random_beats(RAND_BEATS);

    v = '{CFG_W'($urandom_range(250000, 350000)), CFG_W'($urandom_range(0, 100000)),
          CFG_W'($urandom_range(0, 1000000)), CFG_W'($urandom_range(0, 20000)),
          CFG_W'($urandom_range(0, 100000)), CFG_W'($urandom_range(0, 20000)),
          CFG_W'($urandom_range(0, 4000000)), CFG_W'($urandom_range(0, 4000000))};
    write_regs(v);
    random_beats(RAND_BEATS * 2);

    v = '{32'd300186, 32'd25600, 32'd256000, 32'd2560, 32'd12800, 32'd3277,
          32'd214748, 32'd858993};
    write_regs(v);
    random_beats(RAND_BEATS);

    s_axis_tvalid <= 1'b0;
    wait (temps_due.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tnts_pkg.sv
hw/rtl/tnts_cfg.sv
hw/rtl/tnts_dp.sv
hw/rtl/tnts_ctrl.sv
hw/rtl/two_node_thermal_step.sv
sim/two_node_thermal_step_tb.sv
